[design/dll_pkg.sv]
// Shared types and constants for the doubly linked list engine.
// Used by dll_ctrl, dll_datapath, the top level and the checker.
package dll_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int LINK_W      = $clog2(CAPACITY) + 1;
    localparam int STEP_W      = $clog2(CAPACITY + 1);
    localparam int WALK_LAST   = ((CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS) - 1;
    localparam int OUT_SLOT_W  = 5;
    localparam int IO_VALUE_W  = 32;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_AFTER = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_TRAVERSE  = 3'd4,
        CMD_DEL_FRONT = 3'd5,
        CMD_DEL_END   = 3'd6,
        CMD_DEL_KEY   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_STEP,
        DP_TAIL,
        DP_GRAB,
        DP_INS_FE,
        DP_INS_AFTER,
        DP_RELEASE
    } t_dp_op;

    // What goes into the output word
    typedef enum logic [2:0] {
        EM_NONE,
        EM_NODE,
        EM_NEW,
        EM_NOT_FOUND,
        EM_EMPTY,
        EM_FULL
    } t_emit;

    typedef struct packed {
        t_dp_op op;
        t_emit  emit;
        logic   last;
        logic   free_sel;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic p_valid;
        logic match;
        logic walk_done;
        logic next_valid;
        logic trav_end;
        logic free_valid;
        logic out_free;
    } t_dp_stat;

    function automatic logic link_valid(input logic [LINK_W-1:0] s);
        return s < NIL;
    endfunction

endpackage

[design/dll_datapath.sv]
// Datapath: node pool, link arrays, head/tail/free pointers, walk pointer
// and the output word register. Depends on dll_pkg.
module dll_datapath
    import dll_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [2:0]                   i_command,
    input  logic signed [IO_VALUE_W-1:0] i_new_value,
    input  logic signed [IO_VALUE_W-1:0] i_key_value,
    input  t_dp_ctl                      i_ctl,
    output t_dp_stat                     o_stat,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [OUT_SLOT_W-1:0]        o_slot,
    output logic signed [IO_VALUE_W-1:0] o_data_value,
    output logic                         o_last
);

    logic signed [VALUE_BITS-1:0] r_data [CAPACITY];
    logic [LINK_W-1:0]            r_next [CAPACITY];
    logic [LINK_W-1:0]            r_prev [CAPACITY];
    logic [LINK_W-1:0]            r_head, r_tail, r_free, r_p, r_n;
    logic [STEP_W-1:0]            r_steps;
    t_cmd                         r_cmd;
    logic signed [VALUE_BITS-1:0] r_nv, r_key;

    logic [SLOT_W-1:0]            p_idx, f_idx, rd_idx;
    logic [LINK_W-1:0]            rd_next, rd_prev;
    logic signed [VALUE_BITS-1:0] rd_data;
    logic                         out_free;

    assign p_idx   = r_p[SLOT_W-1:0];
    assign f_idx   = r_free[SLOT_W-1:0];
    assign rd_idx  = i_ctl.free_sel ? f_idx : p_idx;
    assign rd_next = r_next[rd_idx];
    assign rd_prev = r_prev[p_idx];
    assign rd_data = r_data[p_idx];
    assign out_free = !o_valid || !i_stall;

    // Report status to the controller
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.p_valid    = link_valid(r_p);
        o_stat.match      = (rd_data == r_key);
        o_stat.walk_done  = (r_steps == STEP_W'(CAPACITY));
        o_stat.next_valid = link_valid(rd_next);
        o_stat.trav_end   = (r_steps == STEP_W'(WALK_LAST));
        o_stat.free_valid = link_valid(r_free);
        o_stat.out_free   = out_free;
    end

    // Pointers and links
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_next[i] <= LINK_W'(i + 1);
            end
            r_head <= NIL;
            r_tail <= NIL;
            r_free <= '0;
            r_p    <= NIL;
        end else begin
            unique case (i_ctl.op)
                DP_LOAD: begin
                    r_p <= r_head;
                end
                DP_STEP: begin
                    r_p <= rd_next;
                end
                DP_TAIL: begin
                    r_p <= r_tail;
                end
                DP_INS_FE: begin
                    r_free <= rd_next;
                    r_data[f_idx] <= r_nv;
                    if (!link_valid(r_head)) begin
                        r_next[f_idx] <= NIL;
                        r_prev[f_idx] <= NIL;
                        r_head <= r_free;
                        r_tail <= r_free;
                    end else if (r_cmd == CMD_INS_FRONT) begin
                        r_next[f_idx] <= r_head;
                        r_prev[f_idx] <= NIL;
                        r_prev[r_head[SLOT_W-1:0]] <= r_free;
                        r_head <= r_free;
                    end else begin
                        r_next[f_idx] <= NIL;
                        r_prev[f_idx] <= r_tail;
                        r_next[r_tail[SLOT_W-1:0]] <= r_free;
                        r_tail <= r_free;
                    end
                end
                DP_INS_AFTER: begin
                    r_free <= rd_next;
                    r_data[f_idx] <= r_nv;
                    r_next[f_idx] <= r_n;
                    r_prev[f_idx] <= r_p;
                    if (link_valid(r_n)) begin
                        r_prev[r_n[SLOT_W-1:0]] <= r_free;
                    end else begin
                        r_tail <= r_free;
                    end
                    r_next[p_idx] <= r_free;
                end
                DP_RELEASE: begin
                    if (link_valid(rd_prev)) begin
                        r_next[rd_prev[SLOT_W-1:0]] <= rd_next;
                    end else begin
                        r_head <= rd_next;
                    end
                    if (link_valid(rd_next)) begin
                        r_prev[rd_next[SLOT_W-1:0]] <= rd_prev;
                    end else begin
                        r_tail <= rd_prev;
                    end
                    r_next[p_idx] <= r_free;
                    r_free <= r_p;
                end
                default: begin
                end
            endcase
        end
    end

    // Latch the command word, count walk steps and keep the next link of the match
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == DP_LOAD) begin
            r_steps <= '0;
        end else if (i_ctl.op == DP_STEP) begin
            r_steps <= r_steps + 1'b1;
        end
        if (i_ctl.op == DP_GRAB) begin
            r_n <= rd_next;
        end
        if (i_accept) begin
            r_cmd <= t_cmd'(i_command);
            r_nv  <= VALUE_BITS'(i_new_value);
            r_key <= VALUE_BITS'(i_key_value);
        end
    end

    // Output word register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.emit != EM_NONE) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit != EM_NONE) begin
            o_last       <= i_ctl.last;
            o_slot       <= '0;
            o_data_value <= '0;
            case (i_ctl.emit)
                EM_NODE: begin
                    o_status     <= ST_OK;
                    o_slot       <= OUT_SLOT_W'(r_p);
                    o_data_value <= IO_VALUE_W'(rd_data);
                end
                EM_NEW: begin
                    o_status     <= ST_OK;
                    o_slot       <= OUT_SLOT_W'(r_free);
                    o_data_value <= IO_VALUE_W'(r_nv);
                end
                EM_NOT_FOUND: o_status <= ST_NOT_FOUND;
                EM_EMPTY:     o_status <= ST_EMPTY;
                default:      o_status <= ST_FULL;
            endcase
        end
    end

endmodule

[design/dll_ctrl.sv]
// Controller state machine: sequences walks, inserts and deletes and
// issues one datapath operation per cycle. Depends on dll_pkg.
module dll_ctrl
    import dll_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_DEL,
        S_FIND,
        S_INSA,
        S_TRAV
    } t_state;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Decode next state and datapath operation
    always_comb begin
        n_state        = r_state;
        o_ctl.op       = DP_NOP;
        o_ctl.emit     = EM_NONE;
        o_ctl.last     = 1'b1;
        o_ctl.free_sel = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_ctl.op = DP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.cmd) inside
                    CMD_INS_FRONT, CMD_INS_END: begin
                        o_ctl.free_sel = 1'b1;
                        if (i_stat.out_free) begin
                            if (i_stat.free_valid) begin
                                o_ctl.op   = DP_INS_FE;
                                o_ctl.emit = EM_NEW;
                            end else begin
                                o_ctl.emit = EM_FULL;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_INS_AFTER, CMD_SEARCH, CMD_DEL_KEY: begin
                        n_state = S_FIND;
                    end
                    CMD_TRAVERSE: begin
                        if (i_stat.p_valid) begin
                            n_state = S_TRAV;
                        end else if (i_stat.out_free) begin
                            o_ctl.emit = EM_EMPTY;
                            n_state    = S_IDLE;
                        end
                    end
                    CMD_DEL_FRONT: begin
                        n_state = S_DEL;
                    end
                    default: begin
                        o_ctl.op = DP_TAIL;
                        n_state  = S_DEL;
                    end
                endcase
            end
            S_DEL: begin
                if (i_stat.out_free) begin
                    if (i_stat.p_valid) begin
                        o_ctl.op   = DP_RELEASE;
                        o_ctl.emit = EM_NODE;
                    end else begin
                        o_ctl.emit = EM_EMPTY;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (!i_stat.p_valid || i_stat.walk_done) begin
                    if (i_stat.out_free) begin
                        o_ctl.emit = EM_NOT_FOUND;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.match) begin
                    if (i_stat.cmd == CMD_INS_AFTER) begin
                        o_ctl.op = DP_GRAB;
                        n_state  = S_INSA;
                    end else if (i_stat.out_free) begin
                        if (i_stat.cmd == CMD_DEL_KEY) begin
                            o_ctl.op = DP_RELEASE;
                        end
                        o_ctl.emit = EM_NODE;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_ctl.op = DP_STEP;
                end
            end
            S_INSA: begin
                o_ctl.free_sel = 1'b1;
                if (i_stat.out_free) begin
                    if (i_stat.free_valid) begin
                        o_ctl.op   = DP_INS_AFTER;
                        o_ctl.emit = EM_NEW;
                    end else begin
                        o_ctl.emit = EM_FULL;
                    end
                    n_state = S_IDLE;
                end
            end
            S_TRAV: begin
                if (i_stat.out_free) begin
                    o_ctl.op   = DP_STEP;
                    o_ctl.emit = EM_NODE;
                    o_ctl.last = !i_stat.next_valid || i_stat.trav_end;
                    if (o_ctl.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/doubly_linked_list_engine.sv]
// Doubly linked list engine: a list of signed values in a fixed node pool.
// Top level joining dll_ctrl and dll_datapath; depends on dll_pkg.
//
// Input channel: i_valid / o_stall with i_command, i_new_value,
// i_key_value. A word is taken when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with o_status, o_slot, o_data_value,
// o_last. o_last marks the final word of each command.
// One command is worked on at a time. Search, insert-after and
// delete-key walk the list one link per cycle. Traverse gives one word
// per cycle while the output is not stalled; the rate is set by the
// single-link-per-cycle walk over the next links. A stalled output word
// holds; traverse pauses until it is taken, while the next input word
// may be accepted once the command is finished. Reset (synchronous,
// active low) empties the list and chains every slot onto the free
// list; no clearing pass is needed.
module doubly_linked_list_engine
    import dll_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_command,
    input  logic signed [IO_VALUE_W-1:0] i_new_value,
    input  logic signed [IO_VALUE_W-1:0] i_key_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [OUT_SLOT_W-1:0]        o_slot,
    output logic signed [IO_VALUE_W-1:0] o_data_value,
    output logic                         o_last
);

    t_dp_ctl  ctl;
    t_dp_stat stat;
    logic     busy;
    logic     accept;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    dll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    dll_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_new_value (i_new_value),
        .i_key_value (i_key_value),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_data_value(o_data_value),
        .o_last      (o_last)
    );

endmodule

[design/dll_checker.sv]
// Port-level checks for the doubly linked list engine, bound to the top.
// Depends on dll_pkg.
module dll_checker
    import dll_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [1:0]            o_status,
    input logic [OUT_SLOT_W-1:0] o_slot,
    input logic [IO_VALUE_W-1:0] o_data_value,
    input logic                  o_last
);

    // No output word right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // A taken command keeps the input side stalled while it runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting a command");

    // Error words always close their command
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last)
        else $error("error word without last marker");

    // Error words carry zero slot and value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_slot == '0 && o_data_value == '0)
        else $error("error word with nonzero payload");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_data_value) && $stable(o_last))
        else $error("stalled output word changed");

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_slot      (o_slot),
    .o_data_value(o_data_value),
    .o_last      (o_last)
);

[tb/tb_doubly_linked_list_engine.sv]
// Testbench for doubly_linked_list_engine: list commands with random idling on both sides.
// Holds its own model of the node pool and compares every output word in order.
// Depends on dll_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine;
    import dll_pkg::*;

    typedef struct {
        t_cmd              cmd;
        logic signed [31:0] nv;
        logic signed [31:0] key;
    } t_req;

    typedef struct {
        logic [1:0]        status;
        logic [4:0]        slot;
        logic signed [31:0] data;
        logic              last;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_command = '0;
    logic signed [31:0] i_new_value = '0;
    logic signed [31:0] i_key_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic [4:0] o_slot;
    logic signed [31:0] o_data_value;
    logic o_last;

    doubly_linked_list_engine DUT (.*);

    // Pool model
    logic [31:0] pool_val [CAPACITY];
    int          nxt [CAPACITY];
    int          prv [CAPACITY];
    int          head, tail, free_top;

    t_req  pending_cmds [$];
    t_resp expected_words [$];
    int    errors = 0;
    int    cycles = 0;
    bit    stim_done = 0;
    bit    quiet = 0;
    int    hold_off = 0;
    bit    hold_done = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void push_word(logic [1:0] st, int s, logic [31:0] d, bit l);
        t_resp r;
        r.status = st; r.slot = s[4:0]; r.data = d; r.last = l;
        expected_words.push_back(r);
    endfunction

    function automatic int find_key(logic [31:0] key);
        int p = head;
        for (int k = 0; k < CAPACITY && p < CAPACITY; k++) begin
            if (pool_val[p] == key) return p;
            p = nxt[p];
        end
        return CAPACITY;
    endfunction

    function automatic int grab(logic [31:0] v);
        int s = free_top;
        if (s >= CAPACITY) return CAPACITY;
        free_top = nxt[s];
        pool_val[s] = v;
        return s;
    endfunction

    function automatic void unlink(int s);
        int p = prv[s];
        int n = nxt[s];
        if (p < CAPACITY) nxt[p] = n; else head = n;
        if (n < CAPACITY) prv[n] = p; else tail = p;
        nxt[s] = free_top;
        free_top = s;
    endfunction

    // Work out the output words of one command and update the pool
    function automatic void predict_list_op(t_req r);
        int s, loc, n, p, k;
        case (r.cmd)
            CMD_INS_FRONT, CMD_INS_END: begin
                s = grab(r.nv);
                if (s >= CAPACITY) begin
                    push_word(ST_FULL, 0, 0, 1);
                end else begin
                    if (head >= CAPACITY) begin
                        nxt[s] = CAPACITY; prv[s] = CAPACITY; head = s; tail = s;
                    end else if (r.cmd == CMD_INS_FRONT) begin
                        nxt[s] = head; prv[s] = CAPACITY; prv[head] = s; head = s;
                    end else begin
                        nxt[s] = CAPACITY; prv[s] = tail;
                        if (tail < CAPACITY) nxt[tail] = s;
                        tail = s;
                    end
                    push_word(ST_OK, s, r.nv, 1);
                end
            end
            CMD_INS_AFTER: begin
                loc = find_key(r.key);
                if (loc >= CAPACITY) begin
                    push_word(ST_NOT_FOUND, 0, 0, 1);
                end else begin
                    s = grab(r.nv);
                    if (s >= CAPACITY) begin
                        push_word(ST_FULL, 0, 0, 1);
                    end else begin
                        n = nxt[loc];
                        nxt[s] = n; prv[s] = loc;
                        if (n < CAPACITY) prv[n] = s; else tail = s;
                        nxt[loc] = s;
                        push_word(ST_OK, s, r.nv, 1);
                    end
                end
            end
            CMD_SEARCH: begin
                loc = find_key(r.key);
                if (loc >= CAPACITY) push_word(ST_NOT_FOUND, 0, 0, 1);
                else push_word(ST_OK, loc, pool_val[loc], 1);
            end
            CMD_TRAVERSE: begin
                p = head;
                k = 0;
                if (p >= CAPACITY) push_word(ST_EMPTY, 0, 0, 1);
                while (p < CAPACITY && k < CAPACITY && k < MAX_RESULTS) begin
                    n = nxt[p];
                    push_word(ST_OK, p, pool_val[p],
                              (n >= CAPACITY) || (k + 1 >= CAPACITY) || (k + 1 >= MAX_RESULTS));
                    k++;
                    p = n;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_END: begin
                s = (r.cmd == CMD_DEL_FRONT) ? head : tail;
                if (s >= CAPACITY) begin
                    push_word(ST_EMPTY, 0, 0, 1);
                end else begin
                    push_word(ST_OK, s, pool_val[s], 1);
                    unlink(s);
                end
            end
            default: begin
                loc = find_key(r.key);
                if (loc >= CAPACITY) begin
                    push_word(ST_NOT_FOUND, 0, 0, 1);
                end else begin
                    push_word(ST_OK, loc, pool_val[loc], 1);
                    unlink(loc);
                end
            end
        endcase
    endfunction

    function automatic void add_cmd(t_cmd c, logic [31:0] nv, logic [31:0] key);
        t_req r;
        r.cmd = c; r.nv = nv; r.key = key;
        pending_cmds.push_back(r);
    endfunction

    // Draw keys mostly from a small set so matches happen often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'hffff_ffff;
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    // Start the pool model empty with every slot on the free chain,
    // then fill the command queue
    initial begin
        int i;
        t_cmd c;
        for (i = 0; i < CAPACITY; i++) begin
            nxt[i] = i + 1;
            prv[i] = CAPACITY;
        end
        head = CAPACITY;
        tail = CAPACITY;
        free_top = 0;
        add_cmd(CMD_TRAVERSE, 0, 0);
        add_cmd(CMD_DEL_FRONT, 0, 0);
        add_cmd(CMD_DEL_END, 0, 0);
        add_cmd(CMD_SEARCH, 0, 5);
        add_cmd(CMD_DEL_KEY, 0, 5);
        add_cmd(CMD_INS_AFTER, 1, 5);
        add_cmd(CMD_INS_FRONT, 32'h8000_0000, 0);
        add_cmd(CMD_INS_END, 32'h7fff_ffff, 0);
        add_cmd(CMD_INS_AFTER, 32'hffff_ffff, 32'h8000_0000);
        add_cmd(CMD_SEARCH, 0, 32'h7fff_ffff);
        add_cmd(CMD_TRAVERSE, 0, 0);
        add_cmd(CMD_DEL_KEY, 0, 32'hffff_ffff);
        add_cmd(CMD_DEL_END, 0, 0);
        add_cmd(CMD_DEL_FRONT, 0, 0);
        // Fill the pool past full, then walk it
        for (i = 0; i < 33; i++) add_cmd(i[0] ? CMD_INS_END : CMD_INS_FRONT, i, 0);
        add_cmd(CMD_INS_AFTER, 99, 3);
        add_cmd(CMD_INS_AFTER, 99, 1000);
        add_cmd(CMD_TRAVERSE, 0, 0);
        add_cmd(CMD_DEL_KEY, 0, 31);
        add_cmd(CMD_INS_AFTER, 77, 31);
        add_cmd(CMD_INS_AFTER, 77, 30);
        add_cmd(CMD_TRAVERSE, 0, 0);
        for (i = 0; i < 15; i++) begin
            c = t_cmd'($urandom_range(0, 7));
            add_cmd(c, pick_value(), pick_value());
        end
        for (i = 0; i < 34; i++) add_cmd(CMD_DEL_END, 0, 0);
        add_cmd(CMD_TRAVERSE, 0, 0);
    end

    // Reset, then let the run finish or time out
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && stim_done && expected_words.size() == 0) begin
            quiet <= 1'b1;
            if (quiet) begin
                repeat (40) @(posedge i_clk);
                if (errors == 0 && expected_words.size() == 0)
                    $display("end of test: clean");
                else
                    $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Driver: offer commands, hold the word while stalled
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_list_op(pending_cmds.pop_front());
            if (!(i_valid && o_stall)) begin
                if (pending_cmds.size() > 0 &&
                    (cycles < 300 || $urandom_range(0, 99) >= 7)) begin
                    r = pending_cmds[0];
                    i_valid <= 1'b1;
                    i_command <= r.cmd;
                    i_new_value <= r.nv;
                    i_key_value <= r.key;
                end else begin
                    i_valid <= 1'b0;
                    if (pending_cmds.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // Count the long hold-off of the output side
    always @(posedge i_clk) begin
        if (i_rst_n && !hold_done && cycles > 400) begin
            hold_off <= hold_off + 1;
            if (hold_off >= 300) hold_done <= 1'b1;
        end
    end

    // Monitor: check each accepted word; hold off once for a long stretch
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word status=%0d slot=%0d data=%0d last=%0d",
                             $time, o_status, o_slot, o_data_value, o_last);
                    errors++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.status !== o_status || e.slot !== o_slot ||
                        e.data !== o_data_value || e.last !== o_last) begin
                        $display("%0t: expected status=%0d slot=%0d data=%0d last=%0d",
                                 $time, e.status, e.slot, e.data, e.last);
                        $display("%0t: actual   status=%0d slot=%0d data=%0d last=%0d",
                                 $time, o_status, o_slot, o_data_value, o_last);
                        errors++;
                    end
                end
            end
            if (!hold_done && cycles > 400) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= (cycles >= 300 && $urandom_range(0, 99) < 7);
            end
        end
    end

endmodule
